[src/mlsp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlsp_pkg
// Shared widths, sequencer states and the tracker status word.
// ----------------------------------------------------------------------------
package mlsp_pkg;

  localparam int VALUE_W     = 32;
  localparam int MAX_REGIONS = 8;
  localparam int REGION_W    = 3;
  localparam int COUNT_W     = 4;
  localparam int OUT_TDATA_W = 48;

  localparam logic [COUNT_W-1:0] MIN_COUNT = 4'd2;
  localparam logic [COUNT_W-1:0] MAX_COUNT = 4'd8;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_HALF,
    ST_EMIT
  } seq_state_t;

  typedef struct packed {
    logic                       done;
    logic [COUNT_W-1:0]         total;
    logic signed [VALUE_W-1:0]  least;
    logic signed [VALUE_W-1:0]  next_least;
    logic [REGION_W-1:0]        least_region;
    logic [REGION_W-1:0]        next_region;
  } trk_t;

endpackage

[src/multi_levelset_projection_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_levelset_projection_core
// Multiple level set projection per grid cell, Q16.16 values.
// ----------------------------------------------------------------------------
//  channel  | direction | word contents
//  ---------+-----------+-----------------------------------------------------
//  in_*     | slave     | phi_value, one region per word, region 0 first
//  out_*    | master    | region, corrected phi, nearest, second; tlast ends cell
//  cfg_*    | write     | region_count, values per cell
//
// Loading accepts one input word per cycle. After the last word of a cell the
// HALF state forms the halved minimum sum, then results leave one at a time:
// one buffer read is in flight at a time and the RAM read data is registered.
// Input is held off from the last word of a cell until its final result leaves.
// Reset clears counters and sequencer; the value buffer is not cleared.
// A stalled output holds its word and the next buffer read waits for it.
module multi_levelset_projection_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [mlsp_pkg::VALUE_W-1:0]          in_tdata,   // [31:0] phi_value
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [2:0] region_index, [34:3] corrected_phi, [37:35] nearest_region,
  // [40:38] second_region, [47:41] zero
  output logic [mlsp_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                  out_tlast,  // last_of_cell
  input  logic                                  cfg_wr_en,
  input  logic [mlsp_pkg::COUNT_W-1:0]          cfg_wr_data // region_count
);
  import mlsp_pkg::*;

  logic [COUNT_W-1:0]  region_count_r;
  logic                in_fire;
  logic [REGION_W-1:0] wr_addr;
  trk_t                trk;
  logic                rd_en;
  logic [REGION_W-1:0] rd_addr;
  logic [VALUE_W-1:0]  rd_data;
  logic [REGION_W-1:0] out_region;
  logic [VALUE_W-1:0]  out_phi;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_count_r <= MIN_COUNT;
    end else if (cfg_wr_en) begin
      region_count_r <= cfg_wr_data;
    end
  end

  assign in_fire = in_tvalid && in_tready;

  mlsp_value_ram #(
    .DEPTH (MAX_REGIONS),
    .WIDTH (VALUE_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (in_fire),
    .wr_addr (wr_addr),
    .wr_data (in_tdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mlsp_tracker u_tracker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .phi          (in_tdata),
    .region_count (region_count_r),
    .wr_addr      (wr_addr),
    .trk          (trk)
  );

  mlsp_emitter u_emitter (
    .clk        (clk),
    .rst_n      (rst_n),
    .trk        (trk),
    .rd_data    (rd_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .in_ready   (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_region (out_region),
    .out_phi    (out_phi),
    .out_last   (out_tlast)
  );

  assign out_tdata = {7'd0, trk.next_region, trk.least_region, out_phi, out_region};

`ifndef SYNTHESIS
  a_no_load_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("input open while a result word is pending");

  a_reopen_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> in_tready)
    else $error("input not reopened after final word of cell");

  a_distinct_regions: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[37:35] != out_tdata[40:38]))
    else $error("nearest and second region coincide");
`endif

endmodule

[src/mlsp_value_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlsp_value_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mlsp_value_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/mlsp_tracker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlsp_tracker
// Counts arriving words and keeps the two smallest values with their regions.
// ----------------------------------------------------------------------------
module mlsp_tracker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_fire,
  input  logic signed [mlsp_pkg::VALUE_W-1:0]  phi,
  input  logic [mlsp_pkg::COUNT_W-1:0]         region_count,
  output logic [mlsp_pkg::REGION_W-1:0]        wr_addr,
  output mlsp_pkg::trk_t                       trk
);
  import mlsp_pkg::*;

  logic [REGION_W-1:0]       arr_cnt_r, arr_cnt_nxt;
  logic signed [VALUE_W-1:0] least_r, least_nxt;
  logic signed [VALUE_W-1:0] next_r, next_nxt;
  logic [REGION_W-1:0]       least_reg_r, least_reg_nxt;
  logic [REGION_W-1:0]       next_reg_r, next_reg_nxt;
  logic [COUNT_W-1:0]        eff_cnt;
  logic [COUNT_W-1:0]        total;
  logic                      cell_end;

  always_comb begin
    if (region_count < MIN_COUNT) begin
      eff_cnt = MIN_COUNT;
    end else if (region_count > MAX_COUNT) begin
      eff_cnt = MAX_COUNT;
    end else begin
      eff_cnt = region_count;
    end
  end

  assign total    = {1'b0, arr_cnt_r} + 4'd1;
  assign cell_end = in_fire && (total >= eff_cnt);

  always_comb begin
    arr_cnt_nxt   = arr_cnt_r;
    least_nxt     = least_r;
    next_nxt      = next_r;
    least_reg_nxt = least_reg_r;
    next_reg_nxt  = next_reg_r;
    if (in_fire) begin
      arr_cnt_nxt = cell_end ? '0 : total[REGION_W-1:0];
      if (arr_cnt_r == '0) begin
        least_nxt     = phi;
        least_reg_nxt = '0;
      end else if (arr_cnt_r == 3'd1) begin
        // first word sits in least_r; a tie hands the minimum to region one
        if (least_r < phi) begin
          next_nxt     = phi;
          next_reg_nxt = 3'd1;
        end else begin
          least_nxt     = phi;
          least_reg_nxt = 3'd1;
          next_nxt      = least_r;
          next_reg_nxt  = '0;
        end
      end else if (phi < least_r) begin
        next_nxt      = least_r;
        next_reg_nxt  = least_reg_r;
        least_nxt     = phi;
        least_reg_nxt = arr_cnt_r;
      end else if (phi < next_r) begin
        next_nxt     = phi;
        next_reg_nxt = arr_cnt_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arr_cnt_r   <= '0;
      least_r     <= '0;
      next_r      <= '0;
      least_reg_r <= '0;
      next_reg_r  <= '0;
    end else begin
      arr_cnt_r   <= arr_cnt_nxt;
      least_r     <= least_nxt;
      next_r      <= next_nxt;
      least_reg_r <= least_reg_nxt;
      next_reg_r  <= next_reg_nxt;
    end
  end

  assign wr_addr = arr_cnt_r;

  always_comb begin
    trk.done         = cell_end;
    trk.total        = total;
    trk.least        = least_r;
    trk.next_least   = next_r;
    trk.least_region = least_reg_r;
    trk.next_region  = next_reg_r;
  end

endmodule

[src/mlsp_emitter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlsp_emitter
// Sequencer: halves the minimum sum, reads the buffer back and emits words.
// ----------------------------------------------------------------------------
module mlsp_emitter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mlsp_pkg::trk_t                       trk,
  input  logic [mlsp_pkg::VALUE_W-1:0]         rd_data,
  output logic                                 rd_en,
  output logic [mlsp_pkg::REGION_W-1:0]        rd_addr,
  output logic                                 in_ready,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [mlsp_pkg::REGION_W-1:0]        out_region,
  output logic [mlsp_pkg::VALUE_W-1:0]         out_phi,
  output logic                                 out_last
);
  import mlsp_pkg::*;

  seq_state_t                st_r, st_nxt;
  logic [COUNT_W-1:0]        total_r;
  logic signed [VALUE_W-1:0] half_r;
  logic [COUNT_W-1:0]        iss_cnt_r;
  logic                      pend_r;
  logic [REGION_W-1:0]       pend_idx_r;
  logic                      out_valid_r;
  logic [REGION_W-1:0]       out_idx_r;
  logic [VALUE_W-1:0]        out_phi_r;
  logic                      out_last_r;
  logic                      out_fire;
  logic                      half_ld;
  logic                      issue;
  logic signed [VALUE_W:0]   min_sum;
  logic signed [VALUE_W:0]   diff;
  logic [VALUE_W-1:0]        sat_phi;
  logic [COUNT_W-1:0]        pend_next;

  assign out_fire = out_valid_r && out_ready;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_LOAD: if (trk.done) st_nxt = ST_HALF;
      ST_HALF: st_nxt = ST_EMIT;
      ST_EMIT: if (out_fire && out_last_r) st_nxt = ST_LOAD;
      default: st_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    half_ld  = 1'b0;
    issue    = 1'b0;
    unique case (st_r)
      ST_LOAD: in_ready = 1'b1;
      ST_HALF: half_ld = 1'b1;
      ST_EMIT: issue = !pend_r && (iss_cnt_r != total_r) && (!out_valid_r || out_ready);
      default: ;
    endcase
  end

  // floor of half the exact sum
  assign min_sum = {trk.least[VALUE_W-1], trk.least}
                 + {trk.next_least[VALUE_W-1], trk.next_least};
  assign diff    = {rd_data[VALUE_W-1], rd_data} - {half_r[VALUE_W-1], half_r};

  always_comb begin
    if (diff[VALUE_W] != diff[VALUE_W-1]) begin
      sat_phi = {diff[VALUE_W], {(VALUE_W-1){~diff[VALUE_W]}}};
    end else begin
      sat_phi = diff[VALUE_W-1:0];
    end
  end

  assign pend_next = {1'b0, pend_idx_r} + 4'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_LOAD;
      iss_cnt_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (half_ld) begin
        iss_cnt_r <= '0;
      end else if (issue) begin
        iss_cnt_r <= iss_cnt_r + 4'd1;
      end
      pend_r <= issue;
      if (pend_r) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_LOAD && trk.done) begin
      total_r <= trk.total;
    end
    if (half_ld) begin
      half_r <= min_sum[VALUE_W:1];
    end
    if (issue) begin
      pend_idx_r <= iss_cnt_r[REGION_W-1:0];
    end
    if (pend_r) begin
      out_idx_r  <= pend_idx_r;
      out_phi_r  <= sat_phi;
      out_last_r <= (pend_next == total_r);
    end
  end

  assign rd_en      = issue;
  assign rd_addr    = iss_cnt_r[REGION_W-1:0];
  assign out_valid  = out_valid_r;
  assign out_region = out_idx_r;
  assign out_phi    = out_phi_r;
  assign out_last   = out_last_r;

endmodule
